// ===== rtl/u8sp_pkg.sv =====
// ============================================================================
// u8sp_pkg
// Shared types, codes and helpers for the 8051-style serial port core.
// ============================================================================
package u8sp_pkg;

    // Default width of the machine cycle arithmetic
    localparam int CYCLE_WIDTH_DEF = 32;

    // Port widths
    localparam int CYCLE_FIELD_W = 32;
    localparam int IN_TDATA_W    = 48;
    localparam int IN_TUSER_W    = 2;
    localparam int OUT_TDATA_W   = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 8;

    // Frame lengths in bits
    localparam logic [3:0] FRAME10_LEN = 4'd10;
    localparam logic [3:0] FRAME11_LEN = 4'd11;

    // Receive sampling offset in mode 2, in machine cycles
    localparam int RX_SAMPLE_OFFSET = 24;

    // Register reset values
    localparam logic [7:0] OVF_DIV_RESET = 8'd32;
    localparam logic [7:0] CYC_DIV_RESET = 8'd64;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_TIMED10 = 2'd1,
        MODE_FIXED11 = 2'd2,
        MODE_TIMED11 = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_TX_WRITE   = 2'd1,
        OP_CTRL_WRITE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CFG_MODE    = 2'd0,
        CFG_SM2     = 2'd1,
        CFG_OVF_DIV = 2'd2,
        CFG_CYC_DIV = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic       fire;
        logic [7:0] count;
    } ovf_res_t;

    // Saturating overflow count against a divider; fire and restart at the divider
    function automatic ovf_res_t ovf_tick(input logic [7:0] cnt, input logic [7:0] div);
        logic [7:0] c;
        ovf_res_t   r;
        c       = (cnt != 8'hFF) ? cnt + 8'd1 : cnt;
        r.fire  = (c >= div);
        r.count = r.fire ? 8'd0 : c;
        return r;
    endfunction

endpackage

// ===== rtl/uart_8051_serial_port_core.sv =====
// ============================================================================
// uart_8051_serial_port_core
// 8051-style serial port, modes 1 to 3: builds and shifts transmit frames,
// samples receive frames and keeps the SCON status flags.
// ============================================================================
//
//  channel   dir  handshake            payload
//  --------  ---  -------------------  ------------------------------------
//  s_*       in   s_tvalid / s_tready  s_tuser: operation; s_tdata: fields
//  m_*       out  m_tvalid / m_tready  m_tdata: pin level, flags, data
//  cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
//  One item per cycle sustained while results are taken; an item passes
//  through the input register, then the state update into the result
//  register. The whole step is one pass of short logic, the mode 2 bit
//  time being a small multiply and one add-and-compare over CYCLE_WIDTH
//  bits.
//  Reset clears all port state: lines idle high, dividers 32 and 64.
//  A stalled result holds its register; the input register still takes an
//  item while the result waits, and only then does s_tready drop.
//
module uart_8051_serial_port_core #(
    parameter int CYCLE_WIDTH = u8sp_pkg::CYCLE_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // s_tdata: [31:0] cycle_count, [32] timer_overflow, [33] rxd_level,
    //          [41:34] tx_byte, [42] receive_enable_value, [43] ninth_bit_value,
    //          [44] rx_flag_value, [45] tx_flag_value, [47:46] zero
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [u8sp_pkg::IN_TDATA_W-1:0]    s_tdata,
    // s_tuser: [1:0] operation
    input  logic [u8sp_pkg::IN_TUSER_W-1:0]    s_tuser,
    // m_tdata: [0] txd_level, [1] rx_flag, [2] tx_flag, [3] rx_ninth_bit,
    //          [11:4] rx_byte, [12] tx_busy, [13] rx_busy, [15:14] zero
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [u8sp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [u8sp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [u8sp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    u8sp_pkg::mode_t mode_reg;
    logic            sm2_reg;
    logic [7:0]      ovf_div_reg;
    logic [7:0]      cyc_div_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= u8sp_pkg::MODE_OFF;
            sm2_reg     <= 1'b0;
            ovf_div_reg <= u8sp_pkg::OVF_DIV_RESET;
            cyc_div_reg <= u8sp_pkg::CYC_DIV_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (u8sp_pkg::cfg_idx_t'(cfg_index))
                u8sp_pkg::CFG_MODE:    mode_reg    <= u8sp_pkg::mode_t'(cfg_data[1:0]);
                u8sp_pkg::CFG_SM2:     sm2_reg     <= cfg_data[0];
                u8sp_pkg::CFG_OVF_DIV: ovf_div_reg <= cfg_data;
                u8sp_pkg::CFG_CYC_DIV: cyc_div_reg <= cfg_data;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic        in_valid_reg;
    logic [1:0]  in_op_reg;
    logic [31:0] in_cycle_reg;
    logic        in_ovf_reg;
    logic        in_rxd_reg;
    logic [7:0]  in_byte_reg;
    logic        in_ren_reg;
    logic        in_tb8_reg;
    logic        in_ri_reg;
    logic        in_ti_reg;

    logic        out_valid_reg;
    logic [u8sp_pkg::OUT_TDATA_W-1:0] out_data_reg;

    logic advance;
    logic in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg    <= s_tuser[1:0];
            in_cycle_reg <= s_tdata[31:0];
            in_ovf_reg   <= s_tdata[32];
            in_rxd_reg   <= s_tdata[33];
            in_byte_reg  <= s_tdata[41:34];
            in_ren_reg   <= s_tdata[42];
            in_tb8_reg   <= s_tdata[43];
            in_ri_reg    <= s_tdata[44];
            in_ti_reg    <= s_tdata[45];
        end
    end

    // ------------------------------------------------------------------
    // Port state
    // ------------------------------------------------------------------
    logic [10:0]            tx_frame_reg,  tx_frame_next;
    logic [3:0]             tx_idx_reg,    tx_idx_next;
    logic [7:0]             tx_cnt_reg,    tx_cnt_next;
    logic [CYCLE_WIDTH-1:0] tx_start_reg,  tx_start_next;
    logic                   tx_active_reg, tx_active_next;
    logic [10:0]            rx_shift_reg,  rx_shift_next;
    logic [3:0]             rx_idx_reg,    rx_idx_next;
    logic [7:0]             rx_cnt_reg,    rx_cnt_next;
    logic [CYCLE_WIDTH-1:0] rx_start_reg,  rx_start_next;
    logic                   rx_active_reg, rx_active_next;
    logic                   last_rxd_reg,  last_rxd_next;
    logic                   last_ren_reg,  last_ren_next;
    logic                   ren_reg,       ren_next;
    logic                   tb8_reg,       tb8_next;
    logic                   rb8_reg,       rb8_next;
    logic                   ri_reg,        ri_next;
    logic                   ti_reg,        ti_next;
    logic [7:0]             rx_buf_reg,    rx_buf_next;
    logic                   txd_reg,       txd_next;

    // Step temporaries
    logic [CYCLE_WIDTH-1:0] now_w;
    logic [11:0]            tx_prod, rx_prod;
    logic [CYCLE_WIDTH-1:0] tx_due, rx_due;
    u8sp_pkg::ovf_res_t     tx_ovf, rx_ovf;
    logic                   tx_step, tx_end, rx_step, rx_end;
    logic [15:0]            tx_frame_ext, rx_shift_ext;

    assign now_w        = CYCLE_WIDTH'(in_cycle_reg);
    assign tx_frame_ext = {5'd0, tx_frame_reg};

    always_comb
    begin
        tx_frame_next  = tx_frame_reg;
        tx_idx_next    = tx_idx_reg;
        tx_cnt_next    = tx_cnt_reg;
        tx_start_next  = tx_start_reg;
        tx_active_next = tx_active_reg;
        rx_shift_next  = rx_shift_reg;
        rx_idx_next    = rx_idx_reg;
        rx_cnt_next    = rx_cnt_reg;
        rx_start_next  = rx_start_reg;
        rx_active_next = rx_active_reg;
        last_rxd_next  = last_rxd_reg;
        last_ren_next  = last_ren_reg;
        ren_next       = ren_reg;
        tb8_next       = tb8_reg;
        rb8_next       = rb8_reg;
        ri_next        = ri_reg;
        ti_next        = ti_reg;
        rx_buf_next    = rx_buf_reg;
        txd_next       = txd_reg;

        tx_prod      = {4'd0, cyc_div_reg} * {8'd0, tx_idx_reg};
        tx_due       = tx_start_reg + {{(CYCLE_WIDTH-12){1'b0}}, tx_prod};
        tx_ovf       = u8sp_pkg::ovf_tick(tx_cnt_reg, ovf_div_reg);
        tx_step      = 1'b0;
        tx_end       = 1'b0;
        rx_prod      = 12'd0;
        rx_due       = '0;
        rx_ovf       = '0;
        rx_step      = 1'b0;
        rx_end       = 1'b0;
        rx_shift_ext = 16'd0;

        unique case (in_op_reg)
            u8sp_pkg::OP_TICK:
            begin
                // Rising REN re-arms the receiver
                if (ren_reg && !last_ren_reg)
                begin
                    rx_idx_next    = 4'd0;
                    rx_shift_next  = 11'd0;
                    rx_active_next = 1'b0;
                    last_rxd_next  = in_rxd_reg;
                end
                last_ren_next = ren_reg;

                // Transmitter
                if (tx_active_reg)
                begin
                    unique case (mode_reg)
                        u8sp_pkg::MODE_TIMED10:
                        begin
                            if (in_ovf_reg)
                            begin
                                tx_cnt_next = tx_ovf.count;
                            end
                            tx_step = in_ovf_reg && tx_ovf.fire;
                            tx_end  = (tx_idx_reg >= u8sp_pkg::FRAME10_LEN);
                        end
                        u8sp_pkg::MODE_FIXED11:
                        begin
                            tx_step = (now_w >= tx_due);
                            tx_end  = (tx_idx_reg == u8sp_pkg::FRAME11_LEN);
                        end
                        u8sp_pkg::MODE_TIMED11:
                        begin
                            if (in_ovf_reg)
                            begin
                                tx_cnt_next = tx_ovf.count;
                            end
                            tx_step = in_ovf_reg && tx_ovf.fire;
                            tx_end  = (tx_idx_reg == u8sp_pkg::FRAME11_LEN);
                        end
                        u8sp_pkg::MODE_OFF:
                        begin
                            tx_step = 1'b0;
                        end
                    endcase
                    if (tx_step)
                    begin
                        if (tx_end)
                        begin
                            tx_active_next = 1'b0;
                            tx_idx_next    = 4'd0;
                            ti_next        = 1'b1;
                            txd_next       = 1'b1;
                        end
                        else
                        begin
                            txd_next    = tx_frame_ext[tx_idx_reg];
                            tx_idx_next = tx_idx_reg + 4'd1;
                        end
                    end
                end

                // Receiver
                if (ren_reg)
                begin
                    if (mode_reg != u8sp_pkg::MODE_OFF)
                    begin
                        // Start bit: falling edge on an idle receiver
                        if (!rx_active_next && !in_rxd_reg && last_rxd_next)
                        begin
                            rx_start_next  = now_w;
                            rx_cnt_next    = ovf_div_reg >> 1;
                            rx_idx_next    = 4'd0;
                            rx_active_next = 1'b1;
                            rx_shift_next  = 11'd0;
                        end
                        last_rxd_next = in_rxd_reg;
                    end

                    if (rx_active_next)
                    begin
                        rx_ovf  = u8sp_pkg::ovf_tick(rx_cnt_next, ovf_div_reg);
                        rx_prod = {4'd0, cyc_div_reg} * {8'd0, rx_idx_next};
                        rx_due  = rx_start_next + CYCLE_WIDTH'(u8sp_pkg::RX_SAMPLE_OFFSET)
                                  + {{(CYCLE_WIDTH-12){1'b0}}, rx_prod};
                        unique case (mode_reg)
                            u8sp_pkg::MODE_TIMED10:
                            begin
                                if (in_ovf_reg)
                                begin
                                    rx_cnt_next = rx_ovf.count;
                                end
                                rx_step = in_ovf_reg && rx_ovf.fire;
                                rx_end  = (rx_idx_next >= u8sp_pkg::FRAME10_LEN);
                            end
                            u8sp_pkg::MODE_FIXED11:
                            begin
                                rx_step = (now_w >= rx_due);
                                rx_end  = (rx_idx_next == u8sp_pkg::FRAME11_LEN);
                            end
                            u8sp_pkg::MODE_TIMED11:
                            begin
                                if (in_ovf_reg)
                                begin
                                    rx_cnt_next = rx_ovf.count;
                                end
                                rx_step = in_ovf_reg && rx_ovf.fire;
                                rx_end  = (rx_idx_next == u8sp_pkg::FRAME11_LEN);
                            end
                            u8sp_pkg::MODE_OFF:
                            begin
                                rx_step = 1'b0;
                            end
                        endcase
                        if (rx_step)
                        begin
                            if (rx_end)
                            begin
                                rx_active_next = 1'b0;
                                rx_idx_next    = 4'd0;
                                // Frame bit 9 is RB8; drop it if RI is still pending
                                if (!ri_reg)
                                begin
                                    rb8_next = rx_shift_next[9];
                                    if (!sm2_reg || rx_shift_next[9])
                                    begin
                                        ri_next     = 1'b1;
                                        rx_buf_next = rx_shift_next[8:1];
                                    end
                                end
                            end
                            else
                            begin
                                rx_shift_ext = {5'd0, rx_shift_next};
                                if (in_rxd_reg)
                                begin
                                    rx_shift_ext[rx_idx_next] = 1'b1;
                                end
                                rx_shift_next = rx_shift_ext[10:0];
                                rx_idx_next   = rx_idx_next + 4'd1;
                            end
                        end
                    end
                end
            end

            u8sp_pkg::OP_TX_WRITE:
            begin
                unique case (mode_reg)
                    u8sp_pkg::MODE_TIMED10:
                        tx_frame_next = {1'b0, 1'b1, in_byte_reg, 1'b0};
                    u8sp_pkg::MODE_FIXED11,
                    u8sp_pkg::MODE_TIMED11:
                        tx_frame_next = {1'b1, tb8_reg, in_byte_reg, 1'b0};
                    u8sp_pkg::MODE_OFF:
                        tx_frame_next = {3'd0, in_byte_reg};
                endcase
                tx_active_next = 1'b1;
                tx_start_next  = now_w;
                tx_cnt_next    = 8'd0;
                tx_idx_next    = 4'd0;
            end

            u8sp_pkg::OP_CTRL_WRITE:
            begin
                ren_next = in_ren_reg;
                tb8_next = in_tb8_reg;
                ri_next  = in_ri_reg;
                ti_next  = in_ti_reg;
            end

            default:
            begin
                // Unused operation: state holds
                ren_next = ren_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_frame_reg  <= 11'd0;
            tx_idx_reg    <= 4'd0;
            tx_cnt_reg    <= 8'd0;
            tx_start_reg  <= '0;
            tx_active_reg <= 1'b0;
            rx_shift_reg  <= 11'd0;
            rx_idx_reg    <= 4'd0;
            rx_cnt_reg    <= 8'd0;
            rx_start_reg  <= '0;
            rx_active_reg <= 1'b0;
            last_rxd_reg  <= 1'b1;
            last_ren_reg  <= 1'b0;
            ren_reg       <= 1'b0;
            tb8_reg       <= 1'b0;
            rb8_reg       <= 1'b0;
            ri_reg        <= 1'b0;
            ti_reg        <= 1'b0;
            rx_buf_reg    <= 8'd0;
            txd_reg       <= 1'b1;
        end
        else if (advance)
        begin
            tx_frame_reg  <= tx_frame_next;
            tx_idx_reg    <= tx_idx_next;
            tx_cnt_reg    <= tx_cnt_next;
            tx_start_reg  <= tx_start_next;
            tx_active_reg <= tx_active_next;
            rx_shift_reg  <= rx_shift_next;
            rx_idx_reg    <= rx_idx_next;
            rx_cnt_reg    <= rx_cnt_next;
            rx_start_reg  <= rx_start_next;
            rx_active_reg <= rx_active_next;
            last_rxd_reg  <= last_rxd_next;
            last_ren_reg  <= last_ren_next;
            ren_reg       <= ren_next;
            tb8_reg       <= tb8_next;
            rb8_reg       <= rb8_next;
            ri_reg        <= ri_next;
            ti_reg        <= ti_next;
            rx_buf_reg    <= rx_buf_next;
            txd_reg       <= txd_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {2'd0, rx_active_next, tx_active_next, rx_buf_next,
                             rb8_next, ti_next, ri_next, txd_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // An idle transmitter always restarts at bit zero
    a_tx_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        !tx_active_reg |-> (tx_idx_reg == 4'd0))
        else $error("transmit bit index left non-zero while idle");

    // An idle receiver always restarts at bit zero
    a_rx_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        !rx_active_reg |-> (rx_idx_reg == 4'd0))
        else $error("receive bit index left non-zero while idle");

    // Input side only stalls when both registers are full and the sink holds off
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

    // Every stepped item lands in the result register
    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("stepped item produced no result");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial port core testbench
// Streams ticks, buffer writes and control writes through the serial port
// under every frame mode and divider extreme. Every result is checked field
// by field against an in-bench model of the port or a fixed expected value,
// with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] OP_SPARE  = 2'd3;
    localparam int         RND_TOTAL = 950;

    // m_tdata[13:0] seen as fields, lowest bit last
    typedef struct packed {
        logic       rx_busy;
        logic       tx_busy;
        logic [7:0] rx_byte;
        logic       rx_ninth_bit;
        logic       tx_flag;
        logic       rx_flag;
        logic       txd_level;
    } port_view_t;

    typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        u8sp_pkg::cfg_idx_t reg_idx;
        logic [7:0]         reg_val;
        logic [1:0]         op;
        logic [31:0]        cycle;
        logic               ovf;
        logic               rxd;
        logic [7:0]         data_byte;
        logic [3:0]         flags;      // TI, RI, TB8, REN
        logic               fixed_want;
        logic [15:0]        want;
    } dir_row_t;

    typedef struct packed {
        u8sp_pkg::mode_t mode;
        logic            sm2;
        logic [7:0]      ovf_div;
        logic [7:0]      cyc_div;
        logic [15:0]     step_max;
        logic            near_wrap;
        logic [15:0]     count;
    } phase_t;

    // kind, reg, value, op, cycle, ovf, rxd, byte, flags, fixed, want
    localparam dir_row_t DIRECTED [0:29] = '{
        '{ROW_ITEM, u8sp_pkg::CFG_MODE, 8'd0, u8sp_pkg::OP_TICK,
          32'h0000_0000, 1'b0, 1'b1, 8'h00, 4'b0000, 1'b1, 16'h0001},
        '{ROW_ITEM, u8sp_pkg::CFG_MODE, 8'd0, u8sp_pkg::OP_CTRL_WRITE,
          32'h0000_0001, 1'b0, 1'b1, 8'h00, 4'b1111, 1'b1, 16'h0007},
        '{ROW_ITEM, u8sp_pkg::CFG_MODE, 8'd0, u8sp_pkg::OP_CTRL_WRITE,
          32'h0000_0002, 1'b1, 1'b0, 8'hFF, 4'b0000, 1'b1, 16'h0001},
        '{ROW_ITEM, u8sp_pkg::CFG_MODE, 8'd0, OP_SPARE,
          32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF, 4'b1111, 1'b1, 16'h0001},
        '{ROW_ITEM, u8sp_pkg::CFG_MODE, 8'd0, u8sp_pkg::OP_TX_WRITE,
          32'hFFFF_FFFF, 1'b1, 1'b0, 8'hFF, 4'b1111, 1'b1, 16'h1001},
        '{ROW_ITEM, u8sp_pkg::CFG_MODE, 8'd0, u8sp_pkg::OP_CTRL_WRITE,
          32'h0000_0005, 1'b0, 1'b0, 8'h00, 4'b0011, 1'b1, 16'h1001},
        '{ROW_ITEM, u8sp_pkg::CFG_MODE, 8'd0, u8sp_pkg::OP_TICK,
          32'h0000_0006, 1'b1, 1'b0, 8'h00, 4'b0000, 1'b1, 16'h1001},
        // switch to mode 1 with the raw mode 0 frame still pending
        '{ROW_REG, u8sp_pkg::CFG_MODE, 8'd1, u8sp_pkg::OP_TICK,
          32'h0, 1'b0, 1'b0, 8'h00, 4'b0000, 1'b0, 16'h0},
        '{ROW_REG, u8sp_pkg::CFG_OVF_DIV, 8'd1, u8sp_pkg::OP_TICK,
          32'h0, 1'b0, 1'b0, 8'h00, 4'b0000, 1'b0, 16'h0},
        '{ROW_ITEM, u8sp_pkg::CFG_MODE, 8'd0, u8sp_pkg::OP_TICK,
          32'd7, 1'b1, 1'b1, 8'h00, 4'b0000, 1'b0, 16'h0},
        '{ROW_ITEM, u8sp_pkg::CFG_MODE, 8'd0, u8sp_pkg::OP_TICK,
          32'd8, 1'b1, 1'b0, 8'h00, 4'b0000, 1'b0, 16'h0},
        '{ROW_ITEM, u8sp_pkg::CFG_MODE, 8'd0, u8sp_pkg::OP_TX_WRITE,
          32'd9, 1'b0, 1'b0, 8'h00, 4'b0000, 1'b0, 16'h0},
        '{ROW_ITEM, u8sp_pkg::CFG_MODE, 8'd0, u8sp_pkg::OP_TICK,
          32'd10, 1'b1, 1'b1, 8'h00, 4'b0000, 1'b0, 16'h0},
        '{ROW_ITEM, u8sp_pkg::CFG_MODE, 8'd0, u8sp_pkg::OP_TICK,
          32'd11, 1'b1, 1'b0, 8'h00, 4'b0000, 1'b0, 16'h0},
        '{ROW_ITEM, u8sp_pkg::CFG_MODE, 8'd0, u8sp_pkg::OP_TICK,
          32'd12, 1'b0, 1'b1, 8'h00, 4'b0000, 1'b0, 16'h0},
        '{ROW_ITEM, u8sp_pkg::CFG_MODE, 8'd0, u8sp_pkg::OP_TICK,
          32'd13, 1'b1, 1'b1, 8'h00, 4'b0000, 1'b0, 16'h0},
        '{ROW_ITEM, u8sp_pkg::CFG_MODE, 8'd0, u8sp_pkg::OP_TICK,
          32'd14, 1'b1, 1'b0, 8'h00, 4'b0000, 1'b0, 16'h0},
        // fixed rate with a zero divider, cycle count wrapping
        '{ROW_REG, u8sp_pkg::CFG_MODE, 8'd2, u8sp_pkg::OP_TICK,
          32'h0, 1'b0, 1'b0, 8'h00, 4'b0000, 1'b0, 16'h0},
        '{ROW_REG, u8sp_pkg::CFG_CYC_DIV, 8'd0, u8sp_pkg::OP_TICK,
          32'h0, 1'b0, 1'b0, 8'h00, 4'b0000, 1'b0, 16'h0},
        '{ROW_ITEM, u8sp_pkg::CFG_MODE, 8'd0, u8sp_pkg::OP_TX_WRITE,
          32'hFFFF_FFF0, 1'b0, 1'b1, 8'hA5, 4'b0000, 1'b0, 16'h0},
        '{ROW_ITEM, u8sp_pkg::CFG_MODE, 8'd0, u8sp_pkg::OP_TICK,
          32'hFFFF_FFFE, 1'b0, 1'b1, 8'h00, 4'b0000, 1'b0, 16'h0},
        '{ROW_ITEM, u8sp_pkg::CFG_MODE, 8'd0, u8sp_pkg::OP_TICK,
          32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00, 4'b0000, 1'b0, 16'h0},
        '{ROW_ITEM, u8sp_pkg::CFG_MODE, 8'd0, u8sp_pkg::OP_TICK,
          32'h0000_0000, 1'b0, 1'b0, 8'h00, 4'b0000, 1'b0, 16'h0},
        '{ROW_REG, u8sp_pkg::CFG_MODE, 8'd3, u8sp_pkg::OP_TICK,
          32'h0, 1'b0, 1'b0, 8'h00, 4'b0000, 1'b0, 16'h0},
        '{ROW_REG, u8sp_pkg::CFG_OVF_DIV, 8'd255, u8sp_pkg::OP_TICK,
          32'h0, 1'b0, 1'b0, 8'h00, 4'b0000, 1'b0, 16'h0},
        '{ROW_REG, u8sp_pkg::CFG_SM2, 8'd1, u8sp_pkg::OP_TICK,
          32'h0, 1'b0, 1'b0, 8'h00, 4'b0000, 1'b0, 16'h0},
        '{ROW_ITEM, u8sp_pkg::CFG_MODE, 8'd0, u8sp_pkg::OP_TICK,
          32'd100, 1'b1, 1'b1, 8'h00, 4'b0000, 1'b0, 16'h0},
        '{ROW_ITEM, u8sp_pkg::CFG_MODE, 8'd0, u8sp_pkg::OP_CTRL_WRITE,
          32'd101, 1'b0, 1'b1, 8'h00, 4'b1110, 1'b0, 16'h0},
        '{ROW_REG, u8sp_pkg::CFG_CYC_DIV, 8'd255, u8sp_pkg::OP_TICK,
          32'h0, 1'b0, 1'b0, 8'h00, 4'b0000, 1'b0, 16'h0},
        '{ROW_ITEM, u8sp_pkg::CFG_MODE, 8'd0, u8sp_pkg::OP_TICK,
          32'd102, 1'b1, 1'b0, 8'h00, 4'b0000, 1'b0, 16'h0}
    };

    // mode, SM2, overflow divider, cycle divider, cycle step, near wrap, items
    localparam phase_t PHASES [0:9] = '{
        '{u8sp_pkg::MODE_TIMED10, 1'b0, 8'd2,   8'd64,  16'd1,   1'b0, 16'd130},
        '{u8sp_pkg::MODE_FIXED11, 1'b0, 8'd32,  8'd3,   16'd2,   1'b1, 16'd130},
        '{u8sp_pkg::MODE_TIMED11, 1'b1, 8'd1,   8'd64,  16'd1,   1'b0, 16'd120},
        '{u8sp_pkg::MODE_FIXED11, 1'b1, 8'd1,   8'd255, 16'd300, 1'b1, 16'd100},
        '{u8sp_pkg::MODE_TIMED10, 1'b1, 8'd0,   8'd1,   16'd1,   1'b0, 16'd90},
        '{u8sp_pkg::MODE_TIMED11, 1'b0, 8'd255, 8'd1,   16'd1,   1'b0, 16'd50},
        '{u8sp_pkg::MODE_OFF,     1'b0, 8'd4,   8'd8,   16'd1,   1'b0, 16'd40},
        '{u8sp_pkg::MODE_TIMED10, 1'b0, 8'd3,   8'd8,   16'd1,   1'b0, 16'd110},
        '{u8sp_pkg::MODE_FIXED11, 1'b0, 8'd3,   8'd0,   16'd1,   1'b0, 16'd60},
        '{u8sp_pkg::MODE_TIMED11, 1'b1, 8'd2,   8'd2,   16'd3,   1'b0, 16'd120}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    // serial port model state
    u8sp_pkg::mode_t sp_mode;
    logic        sp_sm2;
    logic [7:0]  sp_ovf_div;
    logic [7:0]  sp_cyc_div;
    logic [10:0] tx_frame_q;
    logic [3:0]  tx_idx;
    logic [7:0]  tx_ovf_cnt;
    logic [31:0] tx_start;
    logic        tx_on;
    logic [10:0] rx_shift_q;
    logic [3:0]  rx_idx;
    logic [7:0]  rx_ovf_cnt;
    logic [31:0] rx_start;
    logic        rx_on;
    logic        rxd_prev;
    logic        ren_prev;
    logic        ren_f;
    logic        tb8_f;
    logic        rb8_f;
    logic        ri_f;
    logic        ti_f;
    logic [7:0]  rx_latch;
    logic        txd_q;

    port_view_t  results_due [$];
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct  = 7;
    int unsigned recv_idle_pct  = 71;

    uart_8051_serial_port_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic bit_due(input logic [31:0] now, input logic [31:0] start,
                                     input logic [3:0] idx, input logic [31:0] offset);
        logic [31:0] due;
        due = start + offset + {24'd0, sp_cyc_div} * {28'd0, idx};
        return now >= due;
    endfunction

    // saturating count of overflows; fires and restarts once it reaches the divider
    function automatic logic ovf_fire(inout logic [7:0] cnt);
        if (cnt != 8'hFF)
            cnt = cnt + 8'd1;
        if (cnt >= sp_ovf_div)
        begin
            cnt = 8'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void tx_close();
        tx_on  = 1'b0;
        tx_idx = 4'd0;
        ti_f   = 1'b1;
        txd_q  = 1'b1;
    endfunction

    function automatic void tx_shift_out();
        logic [15:0] wide;
        wide   = {5'd0, tx_frame_q} >> tx_idx;
        txd_q  = wide[0];
        tx_idx = tx_idx + 4'd1;
    endfunction

    function automatic void tx_long_bit();
        if (tx_idx == u8sp_pkg::FRAME11_LEN)
            tx_close();
        if (tx_on)
            tx_shift_out();
    endfunction

    function automatic void rx_shift_in(input logic rxd);
        logic [15:0] wide;
        wide = {5'd0, rx_shift_q};
        if (rxd)
            wide[rx_idx] = 1'b1;
        rx_shift_q = wide[10:0];
        rx_idx     = rx_idx + 4'd1;
    endfunction

    // drop the start bit; RB8 follows the frame only while RI is clear
    function automatic void rx_close();
        logic [9:0] word;
        word  = rx_shift_q[10:1];
        rx_on = 1'b0;
        if (!ri_f && ren_f)
        begin
            rb8_f = word[8];
            if (!sp_sm2 || rb8_f)
            begin
                ri_f     = 1'b1;
                rx_latch = word[7:0];
            end
        end
        rx_idx = 4'd0;
    endfunction

    function automatic void rx_long_bit(input logic rxd);
        if (rx_idx == u8sp_pkg::FRAME11_LEN)
            rx_close();
        if (rx_on)
            rx_shift_in(rxd);
    endfunction

    function automatic port_view_t serial_step(input logic [1:0] op, input logic [47:0] f);
        logic [31:0] now;
        logic        ovf;
        logic        rxd;
        logic        ren;
        port_view_t  view;
        now = f[31:0];
        ovf = f[32];
        rxd = f[33];
        case (op)
            u8sp_pkg::OP_TICK:
            begin
                ren = ren_f;
                // a rising REN re-arms the receiver
                if (ren && !ren_prev)
                begin
                    rx_idx     = 4'd0;
                    rx_shift_q = 11'd0;
                    rx_on      = 1'b0;
                    rxd_prev   = rxd;
                end
                ren_prev = ren;
                if (tx_on)
                begin
                    case (sp_mode)
                        u8sp_pkg::MODE_TIMED10:
                        begin
                            if (ovf)
                            begin
                                if (ovf_fire(tx_ovf_cnt))
                                begin
                                    if (tx_idx < u8sp_pkg::FRAME10_LEN)
                                        tx_shift_out();
                                    else
                                        tx_close();
                                end
                            end
                        end
                        u8sp_pkg::MODE_FIXED11:
                        begin
                            if (bit_due(now, tx_start, tx_idx, 32'd0))
                                tx_long_bit();
                        end
                        u8sp_pkg::MODE_TIMED11:
                        begin
                            if (ovf)
                            begin
                                if (ovf_fire(tx_ovf_cnt))
                                    tx_long_bit();
                            end
                        end
                        default: ;
                    endcase
                end
                if (ren)
                begin
                    if (sp_mode != u8sp_pkg::MODE_OFF)
                    begin
                        if (!rx_on && !rxd && rxd_prev)
                        begin
                            rx_start   = now;
                            rx_ovf_cnt = sp_ovf_div >> 1;
                            rx_idx     = 4'd0;
                            rx_on      = 1'b1;
                            rx_shift_q = 11'd0;
                        end
                        rxd_prev = rxd;
                    end
                    if (rx_on)
                    begin
                        case (sp_mode)
                            u8sp_pkg::MODE_TIMED10:
                            begin
                                if (ovf)
                                begin
                                    if (ovf_fire(rx_ovf_cnt))
                                    begin
                                        if (rx_idx < u8sp_pkg::FRAME10_LEN)
                                            rx_shift_in(rxd);
                                        else
                                            rx_close();
                                    end
                                end
                            end
                            u8sp_pkg::MODE_FIXED11:
                            begin
                                if (bit_due(now, rx_start, rx_idx,
                                            u8sp_pkg::RX_SAMPLE_OFFSET))
                                    rx_long_bit(rxd);
                            end
                            u8sp_pkg::MODE_TIMED11:
                            begin
                                if (ovf)
                                begin
                                    if (ovf_fire(rx_ovf_cnt))
                                        rx_long_bit(rxd);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            u8sp_pkg::OP_TX_WRITE:
            begin
                case (sp_mode)
                    u8sp_pkg::MODE_OFF:     tx_frame_q = {3'b000, f[41:34]};
                    u8sp_pkg::MODE_TIMED10: tx_frame_q = {2'b01, f[41:34], 1'b0};
                    default:                tx_frame_q = {1'b1, tb8_f, f[41:34], 1'b0};
                endcase
                tx_on      = 1'b1;
                tx_start   = now;
                tx_ovf_cnt = 8'd0;
                tx_idx     = 4'd0;
            end
            u8sp_pkg::OP_CTRL_WRITE:
            begin
                ren_f = f[42];
                tb8_f = f[43];
                ri_f  = f[44];
                ti_f  = f[45];
            end
            default: ;
        endcase
        view.txd_level    = txd_q;
        view.rx_flag      = ri_f;
        view.tx_flag      = ti_f;
        view.rx_ninth_bit = rb8_f;
        view.rx_byte      = rx_latch;
        view.tx_busy      = tx_on;
        view.rx_busy      = rx_on;
        return view;
    endfunction

    function automatic logic [47:0] pack_fields(input logic [31:0] cycle, input logic ovf,
                                                input logic rxd, input logic [7:0] data_byte,
                                                input logic [3:0] flags);
        return {2'b00, flags, data_byte, rxd, ovf, cycle};
    endfunction

    function automatic void check_field(input string label, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, label, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic push_item(input logic [1:0] op, input logic [47:0] fields,
                             input logic fixed_want, input logic [15:0] want);
        port_view_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= fields;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = serial_step(op, fields);
        results_due.push_back(fixed_want ? port_view_t'(want[13:0]) : predicted);
    endtask

    // hold the sender until every result is back, then let the pipeline settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input u8sp_pkg::cfg_idx_t idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            u8sp_pkg::CFG_MODE:    sp_mode    = u8sp_pkg::mode_t'(val[1:0]);
            u8sp_pkg::CFG_SM2:     sp_sm2     = val[0];
            u8sp_pkg::CFG_OVF_DIV: sp_ovf_div = val;
            u8sp_pkg::CFG_CYC_DIV: sp_cyc_div = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        port_view_t want;
        port_view_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: result %h with none expected", $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = results_due.pop_front();
                got  = port_view_t'(m_tdata[13:0]);
                check_field("txd_level", want.txd_level, got.txd_level);
                check_field("rx_flag", want.rx_flag, got.rx_flag);
                check_field("tx_flag", want.tx_flag, got.tx_flag);
                check_field("rx_ninth_bit", want.rx_ninth_bit, got.rx_ninth_bit);
                check_field("rx_byte", want.rx_byte, got.rx_byte);
                check_field("tx_busy", want.tx_busy, got.tx_busy);
                check_field("rx_busy", want.rx_busy, got.rx_busy);
                check_field("pad", 0, m_tdata[15:14]);
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        logic [31:0] cyc_now;
        logic        rxd_line;
        logic [1:0]  op;
        logic [3:0]  flags;
        int unsigned roll;
        int unsigned rnd_done;
        int unsigned sched;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        sp_mode    = u8sp_pkg::MODE_OFF;
        sp_sm2     = 1'b0;
        sp_ovf_div = u8sp_pkg::OVF_DIV_RESET;
        sp_cyc_div = u8sp_pkg::CYC_DIV_RESET;
        tx_frame_q = '0;
        tx_idx     = '0;
        tx_ovf_cnt = '0;
        tx_start   = '0;
        tx_on      = 1'b0;
        rx_shift_q = '0;
        rx_idx     = '0;
        rx_ovf_cnt = '0;
        rx_start   = '0;
        rx_on      = 1'b0;
        rxd_prev   = 1'b1;
        ren_prev   = 1'b0;
        ren_f      = 1'b0;
        tb8_f      = 1'b0;
        rb8_f      = 1'b0;
        ri_f       = 1'b0;
        ti_f       = 1'b0;
        rx_latch   = '0;
        txd_q      = 1'b1;
        rxd_line   = 1'b1;
        rnd_done   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[r])
        begin
            if (DIRECTED[r].kind == ROW_REG)
            begin
                drain_results();
                write_reg(DIRECTED[r].reg_idx, DIRECTED[r].reg_val);
            end
            else
            begin
                push_item(DIRECTED[r].op,
                          pack_fields(DIRECTED[r].cycle, DIRECTED[r].ovf, DIRECTED[r].rxd,
                                      DIRECTED[r].data_byte, DIRECTED[r].flags),
                          DIRECTED[r].fixed_want, DIRECTED[r].want);
            end
        end

        foreach (PHASES[p])
        begin
            drain_results();
            write_reg(u8sp_pkg::CFG_MODE, {6'd0, PHASES[p].mode});
            write_reg(u8sp_pkg::CFG_SM2, {7'd0, PHASES[p].sm2});
            write_reg(u8sp_pkg::CFG_OVF_DIV, PHASES[p].ovf_div);
            write_reg(u8sp_pkg::CFG_CYC_DIV, PHASES[p].cyc_div);
            if (PHASES[p].near_wrap)
                cyc_now = 32'hFFFF_FFC0 + $urandom_range(31);
            else
                cyc_now = $urandom();
            for (int k = 0; k < PHASES[p].count; k++)
            begin
                sched = (rnd_done * 3) / RND_TOTAL;
                send_idle_pct = (sched == 0) ? 7 : (sched == 1) ? 71 : 0;
                recv_idle_pct = (sched == 0) ? 71 : (sched == 1) ? 7 : 0;
                // favour a new buffer write once the previous frame is out
                roll = $urandom_range(99);
                if (roll < (tx_on ? 2 : 12))
                    op = u8sp_pkg::OP_TX_WRITE;
                else if (roll < (tx_on ? 13 : 23))
                    op = u8sp_pkg::OP_CTRL_WRITE;
                else if (roll < (tx_on ? 16 : 26))
                    op = OP_SPARE;
                else
                    op = u8sp_pkg::OP_TICK;
                flags = $urandom_range(15);
                if (op == u8sp_pkg::OP_CTRL_WRITE)
                begin
                    flags[0] = ($urandom_range(7) != 0);
                    flags[2] = ($urandom_range(3) == 0);
                end
                // hold the line for a few items so that frames look like bit cells
                if ($urandom_range(4) == 0)
                    rxd_line = !rxd_line;
                cyc_now = cyc_now + $urandom_range(PHASES[p].step_max, 1);
                push_item(op, pack_fields(cyc_now, ($urandom_range(9) < 6), rxd_line,
                                          8'($urandom_range(255)), flags), 1'b0, 16'h0);
                rnd_done++;
            end
        end

        drain_results();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== uart_8051_serial_port_core.f =====
rtl/u8sp_pkg.sv
rtl/uart_8051_serial_port_core.sv
tb/testbench.sv
